FILE: rtl/printer_pixel_word_packer_assert.svh
// Assertion macros shared by the pixel word packer RTL.
// Included by the modules that check their own logic; needs no package.
`ifndef PRINTER_PIXEL_WORD_PACKER_ASSERT_SVH
`define PRINTER_PIXEL_WORD_PACKER_ASSERT_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define PPWP_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ppwp check failed");
// Consequent checked in the same cycle as the antecedent.
`define PPWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppwp check failed");
// Consequent checked in the cycle after the antecedent.
`define PPWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppwp check failed");
`else
`define PPWP_ASSERT(lbl, clk, rst_n, cond)
`define PPWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ppwp_pkg.sv
// Package of the pixel word packer: widths, limits, codes and the queue entry type.
// Used by every RTL source file of the block but the assertion header; depends on nothing.
`default_nettype none
package ppwp_pkg;

  localparam int SRC_W      = 8;
  localparam int WORD_W     = 32;
  localparam int DIM_W      = 15;
  localparam int ROW_IDX_W  = 14;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int MAX_WIDTH  = 16384;
  localparam int MAX_HEIGHT = 16384;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Nibble repacking for two bits per pixel, and byte masks for the other modes.
  localparam logic [SRC_W-1:0] MID_PAIR = 8'h0C;
  localparam logic [SRC_W-1:0] LOW_PAIR = 8'h03;
  localparam logic [SRC_W-1:0] KEEP_ALL = 8'hFF;
  localparam logic [SRC_W-1:0] KEEP_3BIT = 8'h77;

  // Register values of bits_mode; zero and five upwards lie outside the legal range.
  localparam logic [2:0] BPP_0 = 3'd0;
  localparam logic [2:0] BPP_1 = 3'd1;
  localparam logic [2:0] BPP_2 = 3'd2;
  localparam logic [2:0] BPP_3 = 3'd3;
  localparam logic [2:0] BPP_4 = 3'd4;
  localparam logic [2:0] BPP_5 = 3'd5;
  localparam logic [2:0] BPP_7 = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BITS_MODE = 2'd0,
    REG_ROW_WIDTH = 2'd1,
    REG_ROW_TOTAL = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_1BIT = 2'd0,
    MODE_2BIT = 2'd1,
    MODE_3BIT = 2'd2,
    MODE_4BIT = 2'd3
  } mode_t;

  // One classified source byte on its way from the front to the back.
  typedef struct packed {
    logic [SRC_W-1:0]  val;
    logic              nib_mode;
    logic [SLOT_W-1:0] slot;
    logic              word_done;
    logic              row_done;
    logic              img_done;
  } op_t;

endpackage
`default_nettype wire

FILE: rtl/ppwp_in_if.sv
// Source byte channel of the pixel word packer.
// Depends on ppwp_pkg for the byte width.
`default_nettype none
interface ppwp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ppwp_pkg::SRC_W-1:0]   src_byte;
  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/ppwp_out_if.sv
// Print word channel of the pixel word packer.
// Depends on ppwp_pkg for the word width.
`default_nettype none
interface ppwp_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppwp_pkg::WORD_W-1:0]  packed_word;
  logic                         row_end;
  logic                         image_end;
  modport source (output valid, output packed_word, output row_end, output image_end,
                  input ready);
  modport sink (input valid, input packed_word, input row_end, input image_end,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/ppwp_cfg_if.sv
// Configuration write channel of the pixel word packer.
// Depends on ppwp_pkg for the index and data widths.
`default_nettype none
interface ppwp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ppwp_pkg::CFG_IDX_W-1:0]   index;
  logic [ppwp_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ppwp_front.sv
// Front end: configuration registers, row and slot tracking, byte classification.
// Depends on ppwp_pkg, ppwp_in_if, ppwp_cfg_if and the assertion header.
`default_nettype none
`include "printer_pixel_word_packer_assert.svh"
module ppwp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ppwp_in_if.sink            in_if,
  ppwp_cfg_if.sink           cfg_if,
  output ppwp_pkg::op_t      op_o,
  output logic               push_o,
  input  wire logic          q_full_i
);

  localparam int DW = ppwp_pkg::DIM_W;

  ppwp_pkg::mode_t                    mode_r, mode_nxt;
  logic [DW-1:0]                      width_r, width_nxt;
  logic [DW-1:0]                      total_r, total_nxt;
  logic [DW-1:0]                      pp_r, pp_nxt;
  logic [ppwp_pkg::ROW_IDX_W-1:0]     row_r, row_nxt;
  logic [ppwp_pkg::SLOT_W-1:0]        slot_r, slot_nxt;

  logic                               m1, m2;
  logic [DW:0]                        pp_sum;
  logic [DW-1:0]                      row_inc;
  logic [DW-1:0]                      pix_left;
  logic [ppwp_pkg::SRC_W-1:0]         inv, keep, val;
  logic                               row_done, word_done, img_done;

  // Sizes below one act as one, sizes above the limit act as the limit.
  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int hi);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) r = DW'(1);
    else if (int'(v) > hi) r = DW'(hi);
    return r;
  endfunction

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !q_full_i;
  assign push_o       = in_if.valid && !q_full_i;

  always_comb begin
    mode_nxt  = mode_r;
    width_nxt = width_r;
    total_nxt = total_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        ppwp_pkg::REG_BITS_MODE: begin
          unique case (cfg_if.data[2:0]) inside
            ppwp_pkg::BPP_0, ppwp_pkg::BPP_1: mode_nxt = ppwp_pkg::MODE_1BIT;
            ppwp_pkg::BPP_2:                  mode_nxt = ppwp_pkg::MODE_2BIT;
            ppwp_pkg::BPP_3:                  mode_nxt = ppwp_pkg::MODE_3BIT;
            default:                          mode_nxt = ppwp_pkg::MODE_4BIT;
          endcase
        end
        ppwp_pkg::REG_ROW_WIDTH: width_nxt = clamp_dim(cfg_if.data, ppwp_pkg::MAX_WIDTH);
        ppwp_pkg::REG_ROW_TOTAL: total_nxt = clamp_dim(cfg_if.data, ppwp_pkg::MAX_HEIGHT);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    m1        = (mode_r == ppwp_pkg::MODE_1BIT);
    m2        = (mode_r == ppwp_pkg::MODE_2BIT);
    pp_sum    = {1'b0, pp_r} + (m1 ? (DW+1)'(8) : (DW+1)'(2));
    row_done  = (pp_sum >= {1'b0, width_r});
    word_done = row_done || (slot_r >= (m2 ? 3'd7 : 3'd3));
    row_inc   = {1'b0, row_r} + DW'(1);
    img_done  = row_done && (row_inc >= total_r);
    inv       = ~in_if.src_byte;
    pix_left  = width_r - pp_r;

    // Pixels past the row width in the last byte of a one-bit row stay blank.
    keep = ppwp_pkg::KEEP_ALL;
    if (pp_r >= width_r) keep = '0;
    else if (pix_left < DW'(8)) keep = 8'(ppwp_pkg::KEEP_ALL << (4'd8 - {1'b0, pix_left[2:0]}));

    case (mode_r)
      ppwp_pkg::MODE_1BIT: val = inv & keep;
      ppwp_pkg::MODE_2BIT: val = ((inv >> 2) & ppwp_pkg::MID_PAIR) | (inv & ppwp_pkg::LOW_PAIR);
      ppwp_pkg::MODE_3BIT: val = inv & ppwp_pkg::KEEP_3BIT;
      default:             val = inv;
    endcase

    op_o.val       = val;
    op_o.nib_mode  = m2;
    op_o.slot      = slot_r;
    op_o.word_done = word_done;
    op_o.row_done  = row_done;
    op_o.img_done  = img_done;

    pp_nxt   = pp_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (push_o) begin
      pp_nxt   = row_done ? '0 : pp_sum[DW-1:0];
      slot_nxt = word_done ? '0 : slot_r + 3'd1;
      if (row_done) row_nxt = img_done ? '0 : row_inc[ppwp_pkg::ROW_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ppwp_pkg::MODE_4BIT;
      width_r <= DW'(1);
      total_r <= DW'(1);
      pp_r    <= '0;
      row_r   <= '0;
      slot_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      width_r <= width_nxt;
      total_r <= total_nxt;
      pp_r    <= pp_nxt;
      row_r   <= row_nxt;
      slot_r  <= slot_nxt;
    end
  end

  `PPWP_ASSERT_NXT(a_row_restart, clk, rst_n, push_o && row_done, pp_r == '0 && slot_r == '0)
  `PPWP_ASSERT(a_width_nonzero, clk, rst_n, width_r != '0 && total_r != '0)
  `PPWP_ASSERT_NXT(a_img_wrap, clk, rst_n, push_o && img_done, row_r == '0)

endmodule
`default_nettype wire

FILE: rtl/ppwp_queue.sv
// Short queue of classified bytes between the front and the back.
// Depends on ppwp_pkg for the entry type and on the assertion header.
`default_nettype none
`include "printer_pixel_word_packer_assert.svh"
module ppwp_queue #(
  parameter int DEPTH = ppwp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_i,
  input  ppwp_pkg::op_t      op_i,
  output logic               full_o,
  output logic               valid_o,
  output ppwp_pkg::op_t      op_o,
  input  wire logic          pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ppwp_pkg::op_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full_o  = (count_r == CW'(DEPTH));
  assign valid_o = (count_r != '0);
  assign op_o    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop_i)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push_i && !pop_i) count_nxt = count_r + CW'(1);
    else if (pop_i && !push_i) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= op_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `PPWP_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `PPWP_ASSERT_IMP(a_no_underflow, clk, rst_n, pop_i, count_r != '0)
  `PPWP_ASSERT_IMP(a_no_overflow, clk, rst_n, push_i, !full_o)

endmodule
`default_nettype wire

FILE: rtl/ppwp_back.sv
// Back end: word accumulator and registered output stage.
// Depends on ppwp_pkg, ppwp_out_if and the assertion header.
`default_nettype none
`include "printer_pixel_word_packer_assert.svh"
module ppwp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          valid_i,
  input  ppwp_pkg::op_t      op_i,
  output logic               pop_o,
  ppwp_out_if.source         out_if
);

  localparam int WW = ppwp_pkg::WORD_W;

  logic [WW-1:0] acc_r, acc_nxt;
  logic [WW-1:0] word_r, word_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          row_end_r, row_end_nxt;
  logic          img_end_r, img_end_nxt;
  logic [WW-1:0] contrib, merged;
  logic          out_free;

  assign out_if.valid       = out_valid_r;
  assign out_if.packed_word = word_r;
  assign out_if.row_end     = row_end_r;
  assign out_if.image_end   = img_end_r;

  always_comb begin
    out_free = !out_valid_r || out_if.ready;
    pop_o    = valid_i && (!op_i.word_done || out_free);

    // Nibble slots count down from the top in two-bit mode, byte slots otherwise.
    if (op_i.nib_mode) contrib = WW'(op_i.val[3:0]) << {~op_i.slot, 2'b00};
    else contrib = WW'(op_i.val) << {~op_i.slot[1:0], 3'b000};
    merged = acc_r | contrib;

    acc_nxt       = acc_r;
    word_nxt      = word_r;
    row_end_nxt   = row_end_r;
    img_end_nxt   = img_end_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (pop_o) begin
      if (op_i.word_done) begin
        acc_nxt       = '0;
        word_nxt      = merged;
        row_end_nxt   = op_i.row_done;
        img_end_nxt   = op_i.img_done;
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt = merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    row_end_r <= row_end_nxt;
    img_end_r <= img_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PPWP_ASSERT_NXT(a_acc_cleared, clk, rst_n, pop_o && op_i.word_done, acc_r == '0)
  `PPWP_ASSERT_IMP(a_img_is_row, clk, rst_n, out_valid_r && img_end_r, row_end_r)
  `PPWP_ASSERT_IMP(a_emit_slot, clk, rst_n, pop_o && op_i.word_done, out_free)

endmodule
`default_nettype wire

FILE: rtl/printer_pixel_word_packer.sv
// Top level of the printer pixel word packer: front, queue and back joined up.
// Depends on ppwp_pkg, the three channel interfaces, ppwp_front, ppwp_queue, ppwp_back.
//
// Usage. Source row bytes arrive one beat at a time on in_if (valid/ready,
// payload src_byte). Each byte is inverted for the print head and packed, first
// pixel in the most significant bits, into 32-bit print words that leave on
// out_if (packed_word, row_end, image_end). A word leaves when it is full or
// when the byte ends the row; the last word of the last row carries image_end.
// Configuration beats on cfg_if set bits_mode (index 0), row_width (index 1)
// and row_total (index 2); cfg_if is always ready, and writes should be made
// while the block holds no unfinished bytes.
// Throughput is one byte per cycle while the receiver takes words; the front
// classifies a byte in the cycle it is accepted, and the back merges one queued
// byte per cycle into the word. A byte that completes its word is written into
// the queue when accepted and then merged into the output register that drives
// out_if. When the receiver stalls, the output register holds its word, the back
// stops merging only on a byte that would complete the next word, the queue of
// QUEUE_DEPTH entries fills and then in_if.ready drops.
// Reset clears the row, slot and word state, empties the queue and returns the
// registers to four bits per pixel, one pixel per row and one row per image.
`default_nettype none
module printer_pixel_word_packer #(
  parameter int QUEUE_DEPTH = ppwp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ppwp_in_if.sink      in_if,
  ppwp_out_if.source   out_if,
  ppwp_cfg_if.sink     cfg_if
);

  ppwp_pkg::op_t  front_op;
  ppwp_pkg::op_t  back_op;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;

  // Front: tracks the position in the row and the slot in the word, so the
  // back never has to tell it anything.
  ppwp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .op_o     (front_op),
    .push_o   (push),
    .q_full_i (q_full)
  );

  ppwp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (back_op),
    .pop_i   (pop)
  );

  // Back: ORs each byte into the accumulator and hands finished words to the
  // output register.
  ppwp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (q_valid),
    .op_i    (back_op),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench of the printer pixel word packer: directed and random row bytes checked
// against a predictor of the packing rules.
// Depends on ppwp_pkg, the three channel interfaces and the top level module.
`timescale 1ns / 1ps
module testbench;

  localparam int RANDOM_ITEMS  = 1400;
  // Bytes sent into a row whose width is written above the limit.
  localparam int WIDE_ROW_BYTES = 64;
  // The queue holds four bytes and feeds the accumulator of the back; this wait lets
  // a byte that completes no word be merged after the last word has left.
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [ppwp_pkg::WORD_W-1:0] word;
    logic                        row_end;
    logic                        image_end;
  } print_word_t;

  logic clk = 1'b0;
  logic rst_n;

  ppwp_in_if  in_ch ();
  ppwp_out_if out_ch ();
  ppwp_cfg_if cfg_ch ();

  printer_pixel_word_packer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The predictor keeps its own copy of the registers and of the packing state.
  logic [2:0]                     reg_mode;
  logic [ppwp_pkg::DIM_W-1:0]     reg_width;
  logic [ppwp_pkg::DIM_W-1:0]     reg_total;
  logic [ppwp_pkg::DIM_W-1:0]     pix_pos;
  logic [ppwp_pkg::ROW_IDX_W-1:0] row_idx;
  logic [ppwp_pkg::WORD_W-1:0]    word_acc;
  logic [ppwp_pkg::SLOT_W-1:0]    slot;

  print_word_t expected_words[$];
  int          fail_count = 0;
  // When set, neither the sender nor the receiver inserts idle cycles.
  bit          no_idle = 1'b0;

  // Packs one accepted source byte and queues the print word it completes, if any.
  function automatic void pack_source_byte(input logic [ppwp_pkg::SRC_W-1:0] b);
    int          mode;
    int          width;
    int          total;
    int          per_byte;
    int          last_slot;
    int          valid_px;
    logic [7:0]  inv;
    logic [7:0]  keep;
    logic [3:0]  nib;
    logic        row_done;
    logic        word_done;
    logic        img_done;
    print_word_t w;

    // Out-of-range modes and sizes are folded onto the nearest legal value.
    mode = (reg_mode < ppwp_pkg::BPP_1) ? int'(ppwp_pkg::BPP_1) :
           (reg_mode > ppwp_pkg::BPP_4) ? int'(ppwp_pkg::BPP_4) : int'(reg_mode);
    width = (reg_width < 1) ? 1 :
            (reg_width > ppwp_pkg::MAX_WIDTH) ? ppwp_pkg::MAX_WIDTH : int'(reg_width);
    total = (reg_total < 1) ? 1 :
            (reg_total > ppwp_pkg::MAX_HEIGHT) ? ppwp_pkg::MAX_HEIGHT : int'(reg_total);
    inv = ~b;
    per_byte = (mode == ppwp_pkg::BPP_1) ? 8 : 2;
    last_slot = (mode == ppwp_pkg::BPP_2) ? 7 : 3;
    row_done = (int'(pix_pos) + per_byte) >= width;
    img_done = 1'b0;

    if (mode == ppwp_pkg::BPP_1) begin
      // Pixels past the row width stay clear.
      keep = ppwp_pkg::KEEP_ALL;
      if (int'(pix_pos) < width) begin
        valid_px = width - int'(pix_pos);
        if (valid_px < 8) keep = ppwp_pkg::KEEP_ALL << (8 - valid_px);
      end else begin
        keep = 8'h00;
      end
      word_acc |= {24'd0, inv & keep} << (24 - 8 * slot[1:0]);
    end else if (mode == ppwp_pkg::BPP_2) begin
      nib = 4'(((inv >> 2) & ppwp_pkg::MID_PAIR) | (inv & ppwp_pkg::LOW_PAIR));
      word_acc |= {28'd0, nib} << (4 * (7 - slot));
    end else begin
      keep = (mode == ppwp_pkg::BPP_3) ? ppwp_pkg::KEEP_3BIT : ppwp_pkg::KEEP_ALL;
      word_acc |= {24'd0, inv & keep} << (24 - 8 * slot[1:0]);
    end

    word_done = row_done || (int'(slot) >= last_slot);

    if (row_done) begin
      pix_pos = '0;
      if (int'(row_idx) + 1 >= total) begin
        img_done = 1'b1;
        row_idx = '0;
      end else begin
        row_idx = row_idx + 1'b1;
      end
    end else begin
      pix_pos = pix_pos + ppwp_pkg::DIM_W'(per_byte);
    end

    if (!word_done) begin
      slot = slot + 1'b1;
    end else begin
      w.word = word_acc;
      w.row_end = row_done;
      w.image_end = img_done;
      expected_words.push_back(w);
      word_acc = '0;
      slot = '0;
    end
  endfunction

  // Offers one byte, with random idle cycles in front unless idling is off, and
  // returns at the edge where the beat is taken.
  task automatic send_byte(input logic [ppwp_pkg::SRC_W-1:0] b);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.src_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    pack_source_byte(b);
  endtask

  // Stops sending and waits until every expected word has left the block, then
  // lets bytes that complete no word finish merging.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ppwp_pkg::cfg_reg_t idx,
                           input logic [ppwp_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      ppwp_pkg::REG_BITS_MODE: reg_mode = value[2:0];
      ppwp_pkg::REG_ROW_WIDTH: reg_width = value;
      ppwp_pkg::REG_ROW_TOTAL: reg_total = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Empties the block and then writes all three registers.
  task automatic set_format(input logic [2:0] mode, input logic [ppwp_pkg::DIM_W-1:0] width,
                            input logic [ppwp_pkg::DIM_W-1:0] total);
    drain();
    write_reg(ppwp_pkg::REG_BITS_MODE, ppwp_pkg::CFG_DATA_W'(mode));
    write_reg(ppwp_pkg::REG_ROW_WIDTH, width);
    write_reg(ppwp_pkg::REG_ROW_TOTAL, total);
  endtask

  // Out of reset the block packs four bits per pixel with one-pixel rows in a
  // one-row image, so every byte closes a row and an image at once.
  task automatic test_reset_values;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h3C);
  endtask

  // A stretch of a row whose width is written above the limit: the row must not
  // end early, and the huge row total means no image end. Cutting the width down
  // afterwards closes the row on the next byte.
  task automatic test_widest_row;
    set_format(ppwp_pkg::BPP_1, 15'h7FFF, 15'h7FFF);
    repeat (WIDE_ROW_BYTES) send_byte(8'($urandom_range(0, 255)));
    drain();
    write_reg(ppwp_pkg::REG_ROW_WIDTH, 15'd1);
    send_byte(8'($urandom_range(0, 255)));
  endtask

  // Each mode in turn, with odd widths, a pad nibble, short rows, zero sizes and
  // both kinds of out-of-range mode.
  task automatic test_bit_modes;
    // Thirteen one-bit pixels: the second byte keeps only its top five bits.
    set_format(ppwp_pkg::BPP_1, 15'd13, 15'd2);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    // Three two-bit pixels: the pad nibble of the second byte is packed as well.
    set_format(ppwp_pkg::BPP_2, 15'd3, 15'd1);
    send_byte(8'h0F);
    send_byte(8'hF0);
    // Zero width and zero rows behave as one, so a single byte flushes the word.
    set_format(ppwp_pkg::BPP_3, 15'd0, 15'd0);
    send_byte(8'h80);
    // Mode zero falls back to one bit per pixel.
    set_format(ppwp_pkg::BPP_0, 15'd1, 15'd1);
    send_byte(8'h7F);
    // Mode five falls back to four bits per pixel.
    set_format(ppwp_pkg::BPP_5, 15'd4, 15'd3);
    send_byte(8'h12);
    send_byte(8'hED);
  endtask

  // Registers rewritten in the middle of a row take effect on the very next byte.
  task automatic test_mid_row_change;
    set_format(ppwp_pkg::BPP_2, 15'd100, 15'd0);
    // Six bytes fill six of the eight nibble slots and leave no word.
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    drain();
    // With four slots per word the held slot index is already past the last one.
    write_reg(ppwp_pkg::REG_BITS_MODE, ppwp_pkg::CFG_DATA_W'(ppwp_pkg::BPP_7));
    send_byte(8'hC3);
    // The row position already lies beyond the new width, so the row ends at once.
    drain();
    write_reg(ppwp_pkg::REG_ROW_WIDTH, 15'd2);
    send_byte(8'h69);
  endtask

  // Random phases, each with a fresh setting and a random length; phases end at
  // arbitrary points of a row, so setting changes fall mid-row as well.
  task automatic test_random_stream;
    int                         sent;
    int                         phase;
    int                         phase_len;
    logic [ppwp_pkg::DIM_W-1:0] width;
    logic [ppwp_pkg::SRC_W-1:0] b;

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: width = '0;
        1: width = ppwp_pkg::DIM_W'($urandom_range(100, 400));
        default: width = ppwp_pkg::DIM_W'($urandom_range(1, 40));
      endcase
      set_format(3'($urandom_range(0, 7)), width, ppwp_pkg::DIM_W'($urandom_range(0, 6)));
      // One phase runs with both sides at full rate.
      no_idle = (phase == 4);
      phase_len = $urandom_range(20, 150);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b);
        sent++;
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // Result checker: each beat on the print word channel is compared with the
  // oldest expected word. The ready line is redrawn every cycle.
  initial begin
    print_word_t w;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected print word %h row_end %b image_end %b", $time,
                   out_ch.packed_word, out_ch.row_end, out_ch.image_end);
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          if (out_ch.packed_word !== w.word) begin
            $display("%0t: packed_word expected %h actual %h", $time, w.word,
                     out_ch.packed_word);
            fail_count++;
          end
          if (out_ch.row_end !== w.row_end) begin
            $display("%0t: row_end expected %b actual %b", $time, w.row_end,
                     out_ch.row_end);
            fail_count++;
          end
          if (out_ch.image_end !== w.image_end) begin
            $display("%0t: image_end expected %b actual %b", $time, w.image_end,
                     out_ch.image_end);
            fail_count++;
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 37);
    end
  end

  // Main sequence: reset, the directed tests, the random stream, then the verdict.
  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.src_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= ppwp_pkg::REG_BITS_MODE;
    cfg_ch.data <= '0;
    reg_mode = ppwp_pkg::BPP_4;
    reg_width = 15'd1;
    reg_total = 15'd1;
    pix_pos = '0;
    row_idx = '0;
    word_acc = '0;
    slot = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_widest_row();
    test_bit_modes();
    test_mid_row_change();
    test_random_stream();

    // Every word must have arrived, and nothing further may follow.
    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ppwp_pkg.sv
rtl/ppwp_in_if.sv
rtl/ppwp_out_if.sv
rtl/ppwp_cfg_if.sv
rtl/ppwp_front.sv
rtl/ppwp_queue.sv
rtl/ppwp_back.sv
rtl/printer_pixel_word_packer.sv
test/testbench.sv
